>>> rtl/kv_trace_occupancy_tracker_macros.svh
// assertion macros for the occupancy tracker
`ifndef KV_TRACE_OCCUPANCY_TRACKER_MACROS_SVH
`define KV_TRACE_OCCUPANCY_TRACKER_MACROS_SVH

// property checked while reset is low
`define KVTR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kvtr assertion failed");

// property checked during reset too
`define KVTR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("kvtr assertion failed");

`endif

>>> rtl/kvtr_pkg.sv
package kvtr_pkg;

   localparam logic [1:0] KIND_GET = 2'd0;
   localparam logic [1:0] KIND_SET = 2'd1;
   localparam logic [1:0] KIND_DEL = 2'd2;
   localparam logic [1:0] KIND_BAD = 2'd3;

   localparam logic [4:0] WINDOW_SHIFT_RESET = 5'd15;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] key;
      logic [31:0] obj_size;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        bad_kind;
      logic        window_end;
      logic [47:0] stored_bytes;
      logic [16:0] live_objects;
      logic [31:0] win_ops;
      logic [31:0] win_gets;
      logic [31:0] win_sets;
      logic [31:0] win_dels;
      logic [31:0] win_set_hits;
      logic [31:0] win_del_hits;
      logic [31:0] win_hits;
   } rsp_type;

   // one resolved operation handed to the statistics unit
   typedef struct packed {
      logic        go;
      logic [1:0]  kind;
      logic        hit;
      logic        last;
      logic [31:0] old_size;
      logic [31:0] new_size;
   } upd_type;

endpackage

>>> rtl/kvtr_ram.sv
module kvtr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/kvtr_clear.sv
module kvtr_clear #(
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   output logic              busy,
   output logic [ADDR_W-1:0] addr
);

   logic              busy_ff;
   logic              busy_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_in;

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + ADDR_W'(1);
         busy_in = (addr_ff != {ADDR_W{1'b1}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign busy = busy_ff;
   assign addr = addr_ff;

endmodule

>>> rtl/kvtr_stats.sv
module kvtr_stats (
   input  logic             clock,
   input  logic             reset,
   input  kvtr_pkg::upd_type upd,
   input  logic [4:0]       window_shift,
   output kvtr_pkg::rsp_type rsp
);

   logic [47:0] total_ff,    total_in;
   logic [16:0] live_ff,     live_in;
   logic [30:0] pos_ff,      pos_in;
   logic [31:0] ops_ff,      ops_in;
   logic [31:0] gets_ff,     gets_in;
   logic [31:0] sets_ff,     sets_in;
   logic [31:0] dels_ff,     dels_in;
   logic [31:0] set_hits_ff, set_hits_in;
   logic [31:0] del_hits_ff, del_hits_in;
   logic [31:0] hits_ff,     hits_in;

   logic        valid;
   logic        is_get;
   logic        is_set;
   logic        is_del;
   logic        hit;
   logic        wend;
   logic [30:0] pos_next;
   logic [30:0] win_mask;
   logic [47:0] add_val;
   logic [47:0] sub_val;
   logic [31:0] ops_n, gets_n, sets_n, dels_n, set_hits_n, del_hits_n, hits_n;
   logic [47:0] total_n;
   logic [16:0] live_n;

   assign valid  = (upd.kind != kvtr_pkg::KIND_BAD);
   assign is_get = (upd.kind == kvtr_pkg::KIND_GET);
   assign is_set = (upd.kind == kvtr_pkg::KIND_SET);
   assign is_del = (upd.kind == kvtr_pkg::KIND_DEL);
   assign hit    = valid && upd.hit;

   assign pos_next = pos_ff + 31'd1;
   assign win_mask = ~(31'h7FFF_FFFF << window_shift);

   assign add_val = is_set ? {16'd0, upd.new_size} : 48'd0;
   assign sub_val = (hit && (is_set || is_del)) ? {16'd0, upd.old_size} : 48'd0;

   always_comb begin
      total_n    = total_ff;
      live_n     = live_ff;
      ops_n      = ops_ff;
      gets_n     = gets_ff;
      sets_n     = sets_ff;
      dels_n     = dels_ff;
      set_hits_n = set_hits_ff;
      del_hits_n = del_hits_ff;
      hits_n     = hits_ff;
      wend       = 1'b0;
      if (valid) begin
         total_n    = total_ff + add_val - sub_val;
         live_n     = live_ff + {16'd0, is_set && !hit} - {16'd0, is_del && hit};
         ops_n      = ops_ff + 32'd1;
         gets_n     = gets_ff + {31'd0, is_get};
         sets_n     = sets_ff + {31'd0, is_set};
         dels_n     = dels_ff + {31'd0, is_del};
         set_hits_n = set_hits_ff + {31'd0, is_set && hit};
         del_hits_n = del_hits_ff + {31'd0, is_del && hit};
         hits_n     = hits_ff + {31'd0, hit};
         wend       = ((pos_next & win_mask) == 31'd0) || upd.last;
      end
   end

   always_comb begin
      total_in    = total_ff;
      live_in     = live_ff;
      pos_in      = pos_ff;
      ops_in      = ops_ff;
      gets_in     = gets_ff;
      sets_in     = sets_ff;
      dels_in     = dels_ff;
      set_hits_in = set_hits_ff;
      del_hits_in = del_hits_ff;
      hits_in     = hits_ff;
      if (upd.go && valid) begin
         total_in = total_n;
         live_in  = live_n;
         pos_in   = upd.last ? 31'd0 : pos_next;
         if (wend) begin
            ops_in      = '0;
            gets_in     = '0;
            sets_in     = '0;
            dels_in     = '0;
            set_hits_in = '0;
            del_hits_in = '0;
            hits_in     = '0;
         end else begin
            ops_in      = ops_n;
            gets_in     = gets_n;
            sets_in     = sets_n;
            dels_in     = dels_n;
            set_hits_in = set_hits_n;
            del_hits_in = del_hits_n;
            hits_in     = hits_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         live_ff     <= '0;
         pos_ff      <= '0;
         ops_ff      <= '0;
         gets_ff     <= '0;
         sets_ff     <= '0;
         dels_ff     <= '0;
         set_hits_ff <= '0;
         del_hits_ff <= '0;
         hits_ff     <= '0;
      end else begin
         total_ff    <= total_in;
         live_ff     <= live_in;
         pos_ff      <= pos_in;
         ops_ff      <= ops_in;
         gets_ff     <= gets_in;
         sets_ff     <= sets_in;
         dels_ff     <= dels_in;
         set_hits_ff <= set_hits_in;
         del_hits_ff <= del_hits_in;
         hits_ff     <= hits_in;
      end
   end

   always_comb begin
      rsp.hit          = hit;
      rsp.bad_kind     = !valid;
      rsp.window_end   = wend;
      rsp.stored_bytes = total_n;
      rsp.live_objects = live_n;
      rsp.win_ops      = ops_n;
      rsp.win_gets     = gets_n;
      rsp.win_sets     = sets_n;
      rsp.win_dels     = dels_n;
      rsp.win_set_hits = set_hits_n;
      rsp.win_del_hits = del_hits_n;
      rsp.win_hits     = hits_n;
   end

endmodule

>>> rtl/kv_trace_occupancy_tracker.sv
// Replays get, set and delete operations against a presence map and a size table
// held in two single-port-write, registered-read memories of 2^KEY_BITS entries, and
// returns one response beat per request beat with the hit flag, the stored byte
// total, the live key count and the current window counters. After reset the
// presence map is swept clean, one entry per cycle, so req_ready stays low until
// the sweep ends; csr writes are taken during that sweep. From then on the block
// takes one request per cycle unless the response side stalls: the memories are
// read as the request is taken, the operation resolves and writes back as it leaves
// the stage-1 register, and a one-entry bypass of the last write covers a request to
// the key updated just before it. Each response is registered from stage 1 into an
// output register, so a stalled consumer holds the pipeline only once it is full.
module kv_trace_occupancy_tracker #(
   parameter int KEY_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kvtr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kvtr_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data
);

   localparam int DEPTH = 1 << KEY_BITS;

   logic                clr_busy;
   logic [KEY_BITS-1:0] clr_addr;

   logic [4:0]          shift_ff;
   logic                req_take;
   logic [KEY_BITS+15:0] key_ext;
   logic [KEY_BITS-1:0] req_idx;

   logic                s1_v_ff, s1_v_in;
   kvtr_pkg::req_type   s1_req_ff;
   logic [KEY_BITS-1:0] s1_idx_ff;
   logic                s1_go;
   logic                s1_set;
   logic                s1_del;

   logic                fwd_v_ff, fwd_v_in;
   logic [KEY_BITS-1:0] fwd_key_ff;
   logic                fwd_present_ff;
   logic [31:0]         fwd_size_ff;
   logic                fwd_hit;

   logic                pres_rd;
   logic [31:0]         size_rd;
   logic                pres_we;
   logic [KEY_BITS-1:0] pres_waddr;
   logic                pres_wdata;

   kvtr_pkg::upd_type   upd;
   kvtr_pkg::rsp_type   rsp_in;
   kvtr_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   kvtr_clear #(
      .ADDR_W (KEY_BITS)
   ) u_clear (
      .clock (clock),
      .reset (reset),
      .busy  (clr_busy),
      .addr  (clr_addr)
   );

   assign key_ext = {{KEY_BITS{1'b0}}, req_data.key};
   assign req_idx = key_ext[KEY_BITS-1:0];

   assign s1_go     = s1_v_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy && (!s1_v_ff || s1_go);
   assign req_take  = req_valid && req_ready;

   assign s1_set = (s1_req_ff.kind == kvtr_pkg::KIND_SET);
   assign s1_del = (s1_req_ff.kind == kvtr_pkg::KIND_DEL);

   assign pres_we    = clr_busy || (s1_go && (s1_set || s1_del));
   assign pres_waddr = clr_busy ? clr_addr : s1_idx_ff;
   assign pres_wdata = !clr_busy && s1_set;

   kvtr_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_present_ram (
      .clock   (clock),
      .wr_en   (pres_we),
      .wr_addr (pres_waddr),
      .wr_data (pres_wdata),
      .rd_en   (req_take),
      .rd_addr (req_idx),
      .rd_data (pres_rd)
   );

   kvtr_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (s1_go && s1_set),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_req_ff.obj_size),
      .rd_en   (req_take),
      .rd_addr (req_idx),
      .rd_data (size_rd)
   );

   // bypass of the most recent write-back
   assign fwd_hit = fwd_v_ff && (fwd_key_ff == s1_idx_ff);

   always_comb begin
      upd.go       = s1_go;
      upd.kind     = s1_req_ff.kind;
      upd.hit      = fwd_hit ? fwd_present_ff : pres_rd;
      upd.last     = s1_req_ff.last_item;
      upd.old_size = fwd_hit ? fwd_size_ff : size_rd;
      upd.new_size = s1_req_ff.obj_size;
   end

   kvtr_stats u_stats (
      .clock        (clock),
      .reset        (reset),
      .upd          (upd),
      .window_shift (shift_ff),
      .rsp          (rsp_in)
   );

   assign s1_v_in      = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_v_ff);
   assign fwd_v_in     = fwd_v_ff || (s1_go && (s1_set || s1_del));
   assign rsp_valid_in = s1_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= kvtr_pkg::WINDOW_SHIFT_RESET;
         s1_v_ff      <= 1'b0;
         fwd_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            shift_ff <= csr_wr_data;
         end
         s1_v_ff      <= s1_v_in;
         fwd_v_ff     <= fwd_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_data;
         s1_idx_ff <= req_idx;
      end
      if (s1_go && (s1_set || s1_del)) begin
         fwd_key_ff     <= s1_idx_ff;
         fwd_present_ff <= s1_set;
      end
      if (s1_go && s1_set) begin
         fwd_size_ff <= s1_req_ff.obj_size;
      end
      if (s1_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/kvtr_assert.sv
`include "kv_trace_occupancy_tracker_macros.svh"

module kvtr_assert (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input kvtr_pkg::rsp_type rsp_data
);

   // response beat holds until taken
   `KVTR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // rejected kind reports neither hit nor window end
   `KVTR_ASSERT(a_bad_shape, clock, reset, rsp_valid && rsp_data.bad_kind |-> !rsp_data.hit && !rsp_data.window_end)

   // a counted beat is always inside its own window
   `KVTR_ASSERT(a_win_ops, clock, reset, rsp_valid && !rsp_data.bad_kind |-> rsp_data.win_ops != 32'd0 && rsp_data.win_hits <= rsp_data.win_ops)

   // map sweep blocks requests and no response is valid after reset
   `KVTR_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !req_ready && !rsp_valid)

endmodule

bind kv_trace_occupancy_tracker kvtr_assert u_kvtr_assert (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data)
);

>>> tb/kv_trace_occupancy_tracker_tb.sv
`timescale 1ns / 100ps

module kv_trace_occupancy_tracker_tb;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   kvtr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   kvtr_pkg::rsp_type rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [4:0]        csr_wr_data = '0;

   kv_trace_occupancy_tracker #(
      .KEY_BITS(16)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow state of the tracker
   bit          present_map [65536];
   bit   [31:0] size_table [65536];
   logic [47:0] byte_total = '0;
   logic [16:0] live_count = '0;
   logic [30:0] window_pos = '0;
   logic [31:0] cnt_ops = '0;
   logic [31:0] cnt_gets = '0;
   logic [31:0] cnt_sets = '0;
   logic [31:0] cnt_dels = '0;
   logic [31:0] cnt_set_hits = '0;
   logic [31:0] cnt_del_hits = '0;
   logic [31:0] cnt_hits = '0;
   logic [4:0]  window_shift = kvtr_pkg::WINDOW_SHIFT_RESET;

   kvtr_pkg::req_type access_q [$];
   kvtr_pkg::rsp_type report_q [$];
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned report_errors = 0;
   logic [15:0] hot_keys [16];

   function automatic kvtr_pkg::rsp_type replay_access(kvtr_pkg::req_type r);
      kvtr_pkg::rsp_type res;
      logic        was_present;
      logic [30:0] wmask;
      res = '0;
      if (r.kind == kvtr_pkg::KIND_BAD) begin
         res.bad_kind = 1'b1;
      end else begin
         was_present = present_map[r.key];
         window_pos = window_pos + 31'd1;
         cnt_ops = cnt_ops + 32'd1;
         if (was_present) cnt_hits = cnt_hits + 32'd1;
         case (r.kind)
            kvtr_pkg::KIND_GET: begin
               cnt_gets = cnt_gets + 32'd1;
            end
            kvtr_pkg::KIND_SET: begin
               cnt_sets = cnt_sets + 32'd1;
               if (was_present) begin
                  cnt_set_hits = cnt_set_hits + 32'd1;
                  byte_total = byte_total - {16'd0, size_table[r.key]};
               end else begin
                  present_map[r.key] = 1'b1;
                  live_count = live_count + 17'd1;
               end
               byte_total = byte_total + {16'd0, r.obj_size};
               size_table[r.key] = r.obj_size;
            end
            default: begin
               cnt_dels = cnt_dels + 32'd1;
               if (was_present) begin
                  cnt_del_hits = cnt_del_hits + 32'd1;
                  byte_total = byte_total - {16'd0, size_table[r.key]};
                  live_count = live_count - 17'd1;
                  present_map[r.key] = 1'b0;
               end
            end
         endcase
         wmask = (31'd1 << window_shift) - 31'd1;
         res.hit = was_present;
         res.window_end = ((window_pos & wmask) == '0) || r.last_item;
      end
      res.stored_bytes = byte_total;
      res.live_objects = live_count;
      res.win_ops = cnt_ops;
      res.win_gets = cnt_gets;
      res.win_sets = cnt_sets;
      res.win_dels = cnt_dels;
      res.win_set_hits = cnt_set_hits;
      res.win_del_hits = cnt_del_hits;
      res.win_hits = cnt_hits;
      if (res.window_end) begin
         cnt_ops = '0;
         cnt_gets = '0;
         cnt_sets = '0;
         cnt_dels = '0;
         cnt_set_hits = '0;
         cnt_del_hits = '0;
         cnt_hits = '0;
      end
      if (r.kind != kvtr_pkg::KIND_BAD && r.last_item) window_pos = '0;
      return res;
   endfunction

   function automatic kvtr_pkg::req_type random_access();
      kvtr_pkg::req_type r;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30) r.kind = kvtr_pkg::KIND_GET;
      else if (pick < 65) r.kind = kvtr_pkg::KIND_SET;
      else if (pick < 90) r.kind = kvtr_pkg::KIND_DEL;
      else r.kind = kvtr_pkg::KIND_BAD;
      r.key = ($urandom_range(99) < 75) ? hot_keys[$urandom_range(15)] : 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 10) r.obj_size = '0;
      else if (pick < 20) r.obj_size = 32'hFFFF_FFFF;
      else r.obj_size = $urandom;
      r.last_item = ($urandom_range(39) == 0);
      return r;
   endfunction

   task automatic push_access(logic [1:0] kind, logic [15:0] key, logic [31:0] size,
                              logic last);
      kvtr_pkg::req_type r;
      r.kind = kind;
      r.key = key;
      r.obj_size = size;
      r.last_item = last;
      access_q.push_back(r);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (access_q.size() != 0 || req_valid || report_q.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_window_shift(logic [4:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      window_shift = value;
      @(negedge clock);
   endtask

   task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
         report_errors++;
         if (report_errors <= 10)
            $display("%s mismatch: expected %0h, got %0h", name, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (access_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_data <= access_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      kvtr_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) report_q.push_back(replay_access(req_data));
         if (rsp_valid && rsp_ready) begin
            if (report_q.size() == 0) begin
               report_errors++;
               if (report_errors <= 10) $display("response beat with nothing outstanding");
            end else begin
               want = report_q.pop_front();
               check_field("hit", want.hit, rsp_data.hit);
               check_field("bad_kind", want.bad_kind, rsp_data.bad_kind);
               check_field("window_end", want.window_end, rsp_data.window_end);
               check_field("stored_bytes", want.stored_bytes, rsp_data.stored_bytes);
               check_field("live_objects", want.live_objects, rsp_data.live_objects);
               check_field("win_ops", want.win_ops, rsp_data.win_ops);
               check_field("win_gets", want.win_gets, rsp_data.win_gets);
               check_field("win_sets", want.win_sets, rsp_data.win_sets);
               check_field("win_dels", want.win_dels, rsp_data.win_dels);
               check_field("win_set_hits", want.win_set_hits, rsp_data.win_set_hits);
               check_field("win_del_hits", want.win_del_hits, rsp_data.win_del_hits);
               check_field("win_hits", want.win_hits, rsp_data.win_hits);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned shift_plan [8];
      int unsigned idle_plan [8];
      int unsigned stall_plan [8];
      shift_plan = '{1, 31, 2, 3, 4, 5, 0, 15};
      idle_plan = '{0, 69, 0, 29, 0, 69, 0, 29};
      stall_plan = '{0, 0, 69, 29, 0, 0, 69, 29};
      shift_plan[6] = $urandom_range(31, 1);
      hot_keys[0] = 16'h0000;
      hot_keys[1] = 16'hFFFF;
      for (int i = 2; i < 16; i++) hot_keys[i] = 16'($urandom);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed beats at the reset window size
      push_access(kvtr_pkg::KIND_GET, 16'h0000, 32'h0000_0000, 1'b0);
      push_access(kvtr_pkg::KIND_SET, 16'h0000, 32'hFFFF_FFFF, 1'b0);
      push_access(kvtr_pkg::KIND_GET, 16'h0000, 32'h0000_0000, 1'b0);
      push_access(kvtr_pkg::KIND_SET, 16'h0000, 32'h1234_5678, 1'b0);
      push_access(kvtr_pkg::KIND_SET, 16'h0000, 32'h0000_0000, 1'b0);
      push_access(kvtr_pkg::KIND_DEL, 16'h0000, 32'hFFFF_FFFF, 1'b0);
      push_access(kvtr_pkg::KIND_DEL, 16'h0000, 32'h0000_0000, 1'b0);
      push_access(kvtr_pkg::KIND_SET, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      push_access(kvtr_pkg::KIND_SET, 16'h8000, 32'h8000_0000, 1'b0);
      push_access(kvtr_pkg::KIND_SET, 16'h0001, 32'h0000_0001, 1'b0);
      push_access(kvtr_pkg::KIND_BAD, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      push_access(kvtr_pkg::KIND_GET, 16'hFFFF, 32'h0000_0000, 1'b1);
      push_access(kvtr_pkg::KIND_SET, 16'hFFFF, 32'h7FFF_FFFF, 1'b0);
      push_access(kvtr_pkg::KIND_DEL, 16'h8000, 32'h0000_0000, 1'b1);
      push_access(kvtr_pkg::KIND_BAD, 16'h0000, 32'h0000_0000, 1'b0);
      push_access(kvtr_pkg::KIND_DEL, 16'hFFFF, 32'h0000_0000, 1'b0);
      push_access(kvtr_pkg::KIND_GET, 16'h0001, 32'h0000_0000, 1'b0);
      push_access(kvtr_pkg::KIND_SET, 16'hAAAA, 32'h5555_5555, 1'b0);
      push_access(kvtr_pkg::KIND_SET, 16'h5555, 32'hAAAA_AAAA, 1'b0);
      push_access(kvtr_pkg::KIND_DEL, 16'hAAAA, 32'h0000_0000, 1'b0);
      push_access(kvtr_pkg::KIND_GET, 16'h5555, 32'h0000_0000, 1'b1);
      push_access(kvtr_pkg::KIND_DEL, 16'h0001, 32'h0000_0000, 1'b0);
      push_access(kvtr_pkg::KIND_DEL, 16'h5555, 32'h0000_0000, 1'b0);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         write_window_shift(5'(shift_plan[p]));
         idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         for (int i = 0; i < 140; i++) access_q.push_back(random_access());
         wait_drained();
      end

      if (report_errors == 0 && report_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
